// ----- sv/tsab_pkg.sv -----
// Shared types, constants and helpers for the bilinear texture sampler.
package tsab_pkg;

    localparam int TEXEL_WORDS_DEF = 131072;
    localparam int MAX_SIZE_DEF    = 256;
    localparam int MAX_LEVEL_DEF   = 8;

    localparam logic [2:0] CFG_TEX_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_TEX_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_ADDR_MODE_U   = 3'd2;
    localparam logic [2:0] CFG_ADDR_MODE_V   = 3'd3;
    localparam logic [2:0] CFG_FILTER_MODE   = 3'd4;
    localparam logic [2:0] CFG_BORDER_RGBA   = 3'd5;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd6;

    localparam logic [1:0] MODE_WRAP   = 2'd0;
    localparam logic [1:0] MODE_CLAMP  = 2'd1;
    localparam logic [1:0] MODE_BORDER = 2'd2;
    localparam logic [1:0] MODE_MIRROR = 2'd3;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [16:0] texel_index;
        logic [31:0] texel_value;
        logic signed [19:0] coord_u;
        logic signed [19:0] coord_v;
        logic [3:0]  level;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       used_border;
    } out_word_t;

    // Remap a Q3.16 coordinate into [0, 1.0]; bit 17 flags a border hit.
    function automatic logic [17:0] remap(input logic [19:0] raw, input logic [1:0] mode);
        logic [19:0] b;
        logic [17:0] r;
        b = raw ^ 20'h80000;
        r = '0;
        case (mode)
            MODE_WRAP:  r = {2'b00, b[15:0]};
            MODE_CLAMP:
            begin
                if (b < 20'h80000)      r = '0;
                else if (b > 20'h90000) r = 18'h10000;
                else                    r = {1'b0, 17'(b - 20'h80000)};
            end
            MODE_BORDER:
            begin
                if (b < 20'h80000 || b > 20'h90000) r = 18'h20000;
                else                                r = {1'b0, 17'(b - 20'h80000)};
            end
            default:
                r = b[16] ? {1'b0, 17'h10000 - {1'b0, b[15:0]}} : {2'b00, b[15:0]};
        endcase
        return r;
    endfunction

    // One channel of a linear blend with an 8-bit weight.
    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] w);
        logic [16:0] s;
        s = 17'(a) * (17'd256 - 17'(w)) + 17'(b) * 17'(w);
        return s[15:8];
    endfunction

endpackage

// ----- sv/tsab_ram.sv -----
// Generic single-port synchronous RAM with registered read.
module tsab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ----- sv/tsab_geom.sv -----
// Mip level geometry: walks levels to find base offset, width and height.
module tsab_geom #(
    parameter int TEXEL_WORDS = tsab_pkg::TEXEL_WORDS_DEF,
    parameter int MAX_SIZE    = tsab_pkg::MAX_SIZE_DEF,
    parameter int MAX_LEVEL   = tsab_pkg::MAX_LEVEL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [3:0]                     level,
    input  logic [8:0]                     tex_width,
    input  logic [8:0]                     tex_height,
    output logic                           done,
    output logic [$clog2(TEXEL_WORDS)-1:0] base,
    output logic [$clog2(MAX_SIZE+1)-1:0]  w,
    output logic [$clog2(MAX_SIZE+1)-1:0]  h
);
    localparam int AW = $clog2(TEXEL_WORDS);
    localparam int SW = $clog2(MAX_SIZE + 1);

    logic          busy_reg;
    logic [3:0]    cnt_reg;
    logic [AW-1:0] base_reg;
    logic [SW-1:0] w_reg, h_reg;

    function automatic logic [SW-1:0] fit(input logic [8:0] s);
        logic [SW-1:0] r;
        if (s == 9'd0)                  r = SW'(1);
        else if (32'(s) > MAX_SIZE)     r = SW'(MAX_SIZE);
        else                            r = SW'(s);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= (32'(level) > MAX_LEVEL) ? 4'(MAX_LEVEL) : level;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 4'd1;
        end
    end

    // Advance one level per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg <= '0;
            w_reg    <= fit(tex_width);
            h_reg    <= fit(tex_height);
        end
        else if (busy_reg && cnt_reg != 4'd0)
        begin
            base_reg <= base_reg + AW'(w_reg) * AW'(h_reg);
            w_reg    <= (w_reg > SW'(1)) ? (w_reg >> 1) : SW'(1);
            h_reg    <= (h_reg > SW'(1)) ? (h_reg >> 1) : SW'(1);
        end
    end

    assign done = busy_reg && cnt_reg == 4'd0;
    assign base = base_reg;
    assign w    = w_reg;
    assign h    = h_reg;
endmodule

// ----- sv/texture_sampler_address_bilinear.sv -----
// Top level of the bilinear texture sampler with address modes.
//
// Usage: words enter on in_valid/in_ready, results leave on out_valid/out_ready.
// A write word (func 0) stores one texel and gives no result.
// A sample word (func 1) gives one result word. It remaps u and v, walks the
// mip chain one level per cycle, multiplies to texel space, then reads the
// single-ported texel memory: one read for point sampling, four for bilinear,
// one texel per cycle, and blends in two registered steps. Border hits and
// channel counts other than 1, 3 or 4 skip the geometry walk and the memory
// and go straight to the last stage to show their result.
// One item is in work at a time; the result sits in an output register, and
// the next word is taken while that result waits. A second finished result
// holds in the last stage, blocking input, until the receiver takes the first.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, unchecked by the block. Reset clears control and
// restores register defaults; the texel memory is undefined until written.
module texture_sampler_address_bilinear #(
    parameter int TEXEL_WORDS = tsab_pkg::TEXEL_WORDS_DEF,
    parameter int MAX_SIZE    = tsab_pkg::MAX_SIZE_DEF,
    parameter int MAX_LEVEL   = tsab_pkg::MAX_LEVEL_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tsab_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tsab_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    localparam int AW = $clog2(TEXEL_WORDS);
    localparam int SW = $clog2(MAX_SIZE + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GEOM  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_RD0   = 9'b000001000,
        S_RD1   = 9'b000010000,
        S_RD2   = 9'b000100000,
        S_RD3   = 9'b001000000,
        S_LAST  = 9'b010000000,
        S_BLEND = 9'b100000000
    } state_t;

    // Configuration registers.
    logic [8:0]  tex_width_reg, tex_height_reg;
    logic [1:0]  mode_u_reg, mode_v_reg;
    logic        filter_reg;
    logic [31:0] border_reg;
    logic [2:0]  chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= 9'd256;
            tex_height_reg <= 9'd256;
            mode_u_reg     <= tsab_pkg::MODE_WRAP;
            mode_v_reg     <= tsab_pkg::MODE_WRAP;
            filter_reg     <= 1'b0;
            border_reg     <= '0;
            chan_reg       <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsab_pkg::CFG_TEX_WIDTH:     tex_width_reg  <= cfg_data[8:0];
                tsab_pkg::CFG_TEX_HEIGHT:    tex_height_reg <= cfg_data[8:0];
                tsab_pkg::CFG_ADDR_MODE_U:   mode_u_reg     <= cfg_data[1:0];
                tsab_pkg::CFG_ADDR_MODE_V:   mode_v_reg     <= cfg_data[1:0];
                tsab_pkg::CFG_FILTER_MODE:   filter_reg     <= cfg_data[0];
                tsab_pkg::CFG_BORDER_RGBA:   border_reg     <= cfg_data;
                tsab_pkg::CFG_CHANNEL_COUNT: chan_reg       <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    state_t      state_reg, state_next;
    logic        out_valid_reg;
    tsab_pkg::out_word_t out_reg;

    logic [16:0] tu_reg, tv_reg;
    logic [SW-1:0] xi_reg, yi_reg, x1_reg, y1_reg, w_reg;
    logic [7:0]  fx_reg, fy_reg;
    logic [AW-1:0] base_reg;
    logic [31:0] t00_reg, t10_reg, t01_reg;
    logic [7:0]  a_reg [4];
    logic [7:0]  b_reg [4];

    logic        geom_done;
    logic [AW-1:0] geom_base;
    logic [SW-1:0] geom_w, geom_h;

    logic        in_fire, out_fire, result_ready;
    logic [17:0] ru, rv;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    // Accept only when idle.
    assign in_ready = (state_reg == S_IDLE);
    assign ru = tsab_pkg::remap(in_data.coord_u, mode_u_reg);
    assign rv = tsab_pkg::remap(in_data.coord_v, mode_v_reg);

    tsab_geom #(
        .TEXEL_WORDS(TEXEL_WORDS), .MAX_SIZE(MAX_SIZE), .MAX_LEVEL(MAX_LEVEL)
    ) u_geom (
        .clk(clk), .rst_n(rst_n),
        .start(state_reg == S_IDLE && in_fire && in_data.func == tsab_pkg::FUNC_SAMPLE
               && !ru[17] && !rv[17]
               && (chan_reg == 3'd1 || chan_reg == 3'd3 || chan_reg == 3'd4)),
        .level(in_data.level), .tex_width(tex_width_reg), .tex_height(tex_height_reg),
        .done(geom_done), .base(geom_base), .w(geom_w), .h(geom_h)
    );

    // Memory address selection.
    logic          ram_we;
    logic [AW-1:0] ram_addr, rd_addr;
    logic [31:0]   ram_rdata;
    logic [SW-1:0] ax, ay;

    always_comb
    begin
        ax = xi_reg;
        ay = yi_reg;
        case (state_reg)
            S_RD1:   ax = x1_reg;
            S_RD2:   ay = y1_reg;
            S_RD3:
            begin
                ax = x1_reg;
                ay = y1_reg;
            end
            default: ;
        endcase
    end

    assign rd_addr = base_reg + AW'(ay) * AW'(w_reg) + AW'(ax);
    assign ram_we  = in_fire && in_data.func == tsab_pkg::FUNC_WRITE
                     && 32'(in_data.texel_index) < TEXEL_WORDS;
    assign ram_addr = ram_we ? AW'(in_data.texel_index) : rd_addr;

    tsab_ram #(.WIDTH(32), .DEPTH(TEXEL_WORDS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_data.texel_value),
        .rdata(ram_rdata)
    );

    // Result finishes this cycle when the output slot is or becomes free.
    assign result_ready = !out_valid_reg || out_ready;

    logic [SW+16:0] gx, gy;
    assign gx = (SW+17)'(tu_reg) * (SW+17)'(geom_w - SW'(1));
    assign gy = (SW+17)'(tv_reg) * (SW+17)'(geom_h - SW'(1));

    logic [7:0] ch [4];
    logic [1:0] sidx [4];
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sidx[c] = (chan_reg == 3'd1) ? 2'd0 : 2'(c);
            ch[c]   = tsab_pkg::lerp8(a_reg[c], b_reg[c], fy_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire && in_data.func == tsab_pkg::FUNC_SAMPLE)
                begin
                    if (ru[17] || rv[17] ||
                        !(chan_reg == 3'd1 || chan_reg == 3'd3 || chan_reg == 3'd4))
                        state_next = S_LAST;
                    else
                        state_next = S_GEOM;
                end
            S_GEOM:  if (geom_done) state_next = S_MUL;
            S_MUL:   state_next = S_RD0;
            S_RD0:   state_next = filter_reg ? S_RD1 : S_BLEND;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_BLEND;
            S_BLEND: state_next = S_LAST;
            S_LAST:  if (result_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LAST && result_ready)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath; a pending result waits in out_reg while the next word works.
    logic special_reg;
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    tu_reg      <= ru[16:0];
                    tv_reg      <= rv[16:0];
                    special_reg <= 1'b1;
                    if (ru[17] || rv[17])
                    begin
                        a_reg[0] <= border_reg[7:0];
                        a_reg[1] <= border_reg[15:8];
                        a_reg[2] <= border_reg[23:16];
                        a_reg[3] <= border_reg[31:24];
                        fx_reg   <= 8'd1;
                    end
                    else
                    begin
                        for (int c = 0; c < 4; c++) a_reg[c] <= 8'd255;
                        fx_reg <= 8'd0;
                    end
                end
            S_GEOM:
            begin
                special_reg <= 1'b0;
            end
            S_MUL:
            begin
                base_reg <= geom_base;
                w_reg    <= geom_w;
                xi_reg   <= SW'(gx >> 16);
                yi_reg   <= SW'(gy >> 16);
                x1_reg   <= (SW'(gx >> 16) + SW'(1) < geom_w) ? SW'(gx >> 16) + SW'(1)
                                                             : geom_w - SW'(1);
                y1_reg   <= (SW'(gy >> 16) + SW'(1) < geom_h) ? SW'(gy >> 16) + SW'(1)
                                                             : geom_h - SW'(1);
                fx_reg   <= filter_reg ? gx[15:8] : 8'd0;
                fy_reg   <= filter_reg ? gy[15:8] : 8'd0;
            end
            S_RD1: t00_reg <= ram_rdata;
            S_RD2: t10_reg <= ram_rdata;
            S_RD3: t01_reg <= ram_rdata;
            S_BLEND:
            begin
                // Data for the last read lands now; point mode: it is t00.
                for (int c = 0; c < 4; c++)
                begin
                    if (filter_reg)
                    begin
                        a_reg[c] <= tsab_pkg::lerp8(t00_reg[8*sidx[c] +: 8],
                                                    t10_reg[8*sidx[c] +: 8], fx_reg);
                        b_reg[c] <= tsab_pkg::lerp8(t01_reg[8*sidx[c] +: 8],
                                                    ram_rdata[8*sidx[c] +: 8], fx_reg);
                    end
                    else
                    begin
                        a_reg[c] <= ram_rdata[8*sidx[c] +: 8];
                        b_reg[c] <= ram_rdata[8*sidx[c] +: 8];
                    end
                end
            end
            S_LAST:
                if (result_ready)
                begin
                    if (special_reg)
                    begin
                        out_reg.red         <= a_reg[0];
                        out_reg.green       <= a_reg[1];
                        out_reg.blue        <= a_reg[2];
                        out_reg.alpha       <= a_reg[3];
                        out_reg.used_border <= fx_reg[0];
                    end
                    else
                    begin
                        out_reg.red         <= ch[0];
                        out_reg.green       <= ch[1];
                        out_reg.blue        <= ch[2];
                        out_reg.alpha       <= (chan_reg == 3'd4) ? ch[3] : 8'd255;
                        out_reg.used_border <= 1'b0;
                    end
                end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
